[rtl/pva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// shared types and constants of the polyphonic voice allocator
// ----------------------------------------------------------------------------
package pva_pkg;

    // default number of voices
    localparam int VOICE_COUNT_DEF = 16;

    // configuration port address width (two 32-bit registers)
    localparam int CFG_AW = 3;

    // highest playable note
    localparam logic [6:0] NOTE_MAX = 7'd127;

    // request opcodes
    typedef enum logic [1:0] {
        ACT_NOTE_ON    = 2'd0,
        ACT_NOTE_OFF   = 2'd1,
        ACT_VOICE_DONE = 2'd2,
        ACT_RESET_ALL  = 2'd3
    } t_action;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RETRIG,
        ST_RELEASE,
        ST_DONE_CHK,
        ST_STEAL_SCAN,
        ST_STEAL_PICK,
        ST_STEAL_FREE,
        ST_FREE_SCAN,
        ST_ALLOC,
        ST_FINISH
    } t_state;

    // configuration register contents
    typedef struct packed {
        logic [6:0] transpose;
        logic       phase_sync;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clr_sel;
        logic inc_sel;
        logic load_sel_map;
        logic load_sel_done;
        logic load_sel_pick;
        logic scan_step;
        logic retrig;
        logic release_voice;
        logic free_done;
        logic free_steal;
        logic alloc;
        logic clear_all;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_action action;
        logic    map_hit;
        logic    full;
        logic    done_in_range;
        logic    sel_age_zero;
        logic    sel_last;
    } t_dp_status;

endpackage

[rtl/pva_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_regs
// apb configuration registers: transpose offset and phase sync enable
// ----------------------------------------------------------------------------
module pva_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pva_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pva_pkg::t_cfg               o_cfg
);
    import pva_pkg::*;

    localparam logic REG_TRANSPOSE  = 1'b0;
    localparam logic REG_PHASE_SYNC = 1'b1;

    logic       w_reg_idx;
    logic       w_wr;
    logic [6:0] r_transpose;
    logic       r_phase_sync;

    assign w_reg_idx = paddr[CFG_AW-1];
    assign w_wr      = psel & penable & pwrite;
    assign pready    = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose  <= '0;
            r_phase_sync <= 1'b0;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_TRANSPOSE:  r_transpose  <= pwdata[6:0];
                REG_PHASE_SYNC: r_phase_sync <= pwdata[0];
                default:        r_transpose  <= r_transpose;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_reg_idx)
            REG_TRANSPOSE:  prdata = {25'd0, r_transpose};
            REG_PHASE_SYNC: prdata = {31'd0, r_phase_sync};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.transpose  = r_transpose;
    assign o_cfg.phase_sync = r_phase_sync;

endmodule

[rtl/pva_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_ctrl
// request sequencer: decodes the event and steps the datapath through scans
// ----------------------------------------------------------------------------
module pva_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output logic                 o_result_valid,
    input  pva_pkg::t_dp_status  i_status,
    output pva_pkg::t_dp_cmd     o_cmd
);
    import pva_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    // state register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_FINISH);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (i_status.action)
                    ACT_NOTE_ON: begin
                        if (i_status.map_hit)   n_state = ST_RETRIG;
                        else if (i_status.full) n_state = ST_STEAL_SCAN;
                        else                    n_state = ST_FREE_SCAN;
                    end
                    ACT_NOTE_OFF: begin
                        n_state = i_status.map_hit ? ST_RELEASE : ST_FINISH;
                    end
                    ACT_VOICE_DONE: begin
                        n_state = i_status.done_in_range ? ST_DONE_CHK : ST_FINISH;
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_RETRIG:     n_state = ST_FINISH;
            ST_RELEASE:    n_state = ST_FINISH;
            ST_DONE_CHK:   n_state = ST_FINISH;
            ST_STEAL_SCAN: begin
                if (i_status.sel_last) n_state = ST_STEAL_PICK;
            end
            ST_STEAL_PICK: n_state = ST_STEAL_FREE;
            ST_STEAL_FREE: n_state = ST_ALLOC;
            ST_FREE_SCAN: begin
                if (i_status.sel_age_zero)  n_state = ST_ALLOC;
                else if (i_status.sel_last) n_state = ST_FINISH;
            end
            ST_ALLOC:      n_state = ST_FINISH;
            ST_FINISH:     n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_start;
            end
            ST_DECODE: begin
                case (i_status.action)
                    ACT_NOTE_ON: begin
                        o_cmd.load_sel_map = i_status.map_hit;
                        o_cmd.clr_sel      = !i_status.map_hit;
                    end
                    ACT_NOTE_OFF:   o_cmd.load_sel_map  = i_status.map_hit;
                    ACT_VOICE_DONE: o_cmd.load_sel_done = i_status.done_in_range;
                    default:        o_cmd.clear_all     = 1'b1;
                endcase
            end
            ST_RETRIG:     o_cmd.retrig        = 1'b1;
            ST_RELEASE:    o_cmd.release_voice = 1'b1;
            ST_DONE_CHK:   o_cmd.free_done     = !i_status.sel_age_zero;
            ST_STEAL_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.inc_sel   = !i_status.sel_last;
            end
            ST_STEAL_PICK: o_cmd.load_sel_pick = 1'b1;
            ST_STEAL_FREE: o_cmd.free_steal    = 1'b1;
            ST_FREE_SCAN: begin
                o_cmd.inc_sel = !i_status.sel_age_zero && !i_status.sel_last;
            end
            ST_ALLOC:      o_cmd.alloc = 1'b1;
            default:       o_cmd = '0;
        endcase
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_strobe;

    // checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == ST_IDLE))
        else $error("result strobe while a request is in progress");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_DECODE))
        else $error("accepted request not decoded");

    a_steal_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEAL_FREE) |=> (r_state == ST_ALLOC))
        else $error("stolen voice not reallocated");

endmodule

[rtl/pva_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_dp
// voice state, note map memory, scan registers and result registers
// ----------------------------------------------------------------------------
module pva_dp #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pva_pkg::t_dp_cmd     i_cmd,
    output pva_pkg::t_dp_status  o_status,
    input  pva_pkg::t_cfg        i_cfg,
    input  logic [1:0]           i_action,
    input  logic [6:0]           i_note,
    input  logic [6:0]           i_velocity,
    input  logic [3:0]           i_channel,
    input  logic [3:0]           i_done_voice,
    output logic [3:0]           o_voice,
    output logic                 o_voice_valid,
    output logic                 o_retriggered,
    output logic                 o_stole,
    output logic [3:0]           o_stolen_voice,
    output logic [6:0]           o_played_note,
    output logic                 o_restart_phase,
    output logic [4:0]           o_active_voices
);
    import pva_pkg::*;

    localparam int              IW       = $clog2(VOICE_COUNT);
    localparam int              AW       = $clog2(VOICE_COUNT + 1);
    localparam logic [AW-1:0]   VC_A     = AW'(VOICE_COUNT);
    localparam logic [AW-1:0]   ONE_AGE  = AW'(1);
    localparam logic [IW-1:0]   LAST_SEL = IW'(VOICE_COUNT - 1);
    localparam int              NOTES    = 128;

    // latched request
    t_action     r_action;
    logic [6:0]  r_note;
    logic [6:0]  r_vel;
    logic [3:0]  r_ch;
    logic [3:0]  r_done;

    // per-voice state
    logic [AW-1:0]          r_age   [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_rel;
    logic [6:0]             r_vnote [VOICE_COUNT];
    logic [6:0]             r_vvel  [VOICE_COUNT];
    logic [3:0]             r_vch   [VOICE_COUNT];
    logic [AW-1:0]          r_active;

    // note map: voice memory plus valid flops
    logic [IW-1:0]          r_map_mem [NOTES];
    logic [IW-1:0]          r_map_q;
    logic [NOTES-1:0]       r_map_vld;

    // voice pointer and steal scan
    logic [IW-1:0]          r_sel;
    logic [AW-1:0]          r_best;
    logic                   r_found;
    logic [IW-1:0]          r_pick_rel;
    logic [IW-1:0]          r_pick_old;

    // result registers
    logic [IW-1:0]          r_res_voice;
    logic                   r_res_valid;
    logic                   r_res_retrig;
    logic                   r_res_stole;
    logic [IW-1:0]          r_res_stolen;
    logic [6:0]             r_res_played;
    logic                   r_res_restart;

    logic [AW-1:0]          w_sel_age;
    logic                   w_sel_rel;
    logic [6:0]             w_sel_vnote;
    logic [IW-1:0]          w_pick;
    logic                   w_free;
    logic signed [8:0]      w_sum;
    logic [6:0]             w_played;

    assign w_sel_age   = r_age[r_sel];
    assign w_sel_rel   = r_rel[r_sel];
    assign w_sel_vnote = r_vnote[r_sel];
    assign w_pick      = r_found ? r_pick_rel : r_pick_old;
    assign w_free      = i_cmd.free_done | i_cmd.free_steal;

    // transpose and clamp
    always_comb begin
        w_sum = $signed({2'b00, i_note})
              + $signed({{2{i_cfg.transpose[6]}}, i_cfg.transpose});
        if (w_sum < 0)             w_played = '0;
        else if (w_sum > 9'sd127)  w_played = NOTE_MAX;
        else                       w_played = w_sum[6:0];
    end

    // status to controller
    assign o_status.action        = r_action;
    assign o_status.map_hit       = r_map_vld[r_note];
    assign o_status.full          = (r_active >= VC_A);
    assign o_status.done_in_range = (32'(r_done) < 32'(VOICE_COUNT));
    assign o_status.sel_age_zero  = (w_sel_age == '0);
    assign o_status.sel_last      = (r_sel == LAST_SEL);

    // request latch and note map read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= t_action'(i_action);
            r_note   <= i_note;
            r_vel    <= i_velocity;
            r_ch     <= i_channel;
            r_done   <= i_done_voice;
            r_map_q  <= r_map_mem[i_note];
        end
        if (i_cmd.alloc) begin
            r_map_mem[r_note] <= r_sel;
        end
    end

    // ages, released flags, map valid bits, active count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICE_COUNT; v++) r_age[v] <= '0;
            r_rel     <= '0;
            r_map_vld <= '0;
            r_active  <= '0;
        end else if (i_cmd.clear_all) begin
            for (int v = 0; v < VOICE_COUNT; v++) r_age[v] <= '0;
            r_rel     <= '0;
            r_map_vld <= '0;
            r_active  <= '0;
        end else if (w_free) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                if (r_age[v] > w_sel_age) r_age[v] <= r_age[v] - ONE_AGE;
            end
            r_age[r_sel]           <= '0;
            r_rel[r_sel]           <= 1'b0;
            r_map_vld[w_sel_vnote] <= 1'b0;
            r_active               <= r_active - ONE_AGE;
        end else if (i_cmd.retrig) begin
            // move to newest, close the gap behind it
            for (int v = 0; v < VOICE_COUNT; v++) begin
                if (r_age[v] > w_sel_age) r_age[v] <= r_age[v] - ONE_AGE;
            end
            r_age[r_sel] <= r_active;
            r_rel[r_sel] <= 1'b0;
        end else if (i_cmd.release_voice) begin
            r_rel[r_sel] <= 1'b1;
        end else if (i_cmd.alloc) begin
            r_age[r_sel]      <= r_active + ONE_AGE;
            r_rel[r_sel]      <= 1'b0;
            r_map_vld[r_note] <= 1'b1;
            r_active          <= r_active + ONE_AGE;
        end
    end

    // stored voice parameters
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_vnote[r_sel] <= r_note;
            r_vvel[r_sel]  <= r_vel;
            r_vch[r_sel]   <= r_ch;
        end else if (i_cmd.retrig) begin
            r_vvel[r_sel]  <= r_vel;
        end
    end

    // voice pointer and steal candidate tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_sel) begin
            r_sel   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.inc_sel) begin
            r_sel <= r_sel + 1'b1;
        end else if (i_cmd.load_sel_map) begin
            r_sel <= r_map_q;
        end else if (i_cmd.load_sel_done) begin
            r_sel <= IW'(r_done);
        end else if (i_cmd.load_sel_pick) begin
            r_sel <= w_pick;
        end
        if (i_cmd.scan_step) begin
            if ((w_sel_age != '0) && w_sel_rel && (!r_found || (w_sel_age < r_best))) begin
                r_best     <= w_sel_age;
                r_pick_rel <= r_sel;
                r_found    <= 1'b1;
            end
            if (w_sel_age == ONE_AGE) r_pick_old <= r_sel;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_voice   <= '0;
            r_res_valid   <= 1'b0;
            r_res_retrig  <= 1'b0;
            r_res_stole   <= 1'b0;
            r_res_stolen  <= '0;
            r_res_restart <= 1'b0;
            r_res_played  <= (t_action'(i_action) == ACT_NOTE_ON) ? w_played : '0;
        end
        if (i_cmd.retrig || i_cmd.release_voice || i_cmd.free_done || i_cmd.alloc) begin
            r_res_voice <= r_sel;
            r_res_valid <= 1'b1;
        end
        if (i_cmd.retrig)     r_res_retrig  <= 1'b1;
        if (i_cmd.alloc)      r_res_restart <= i_cfg.phase_sync;
        if (i_cmd.free_steal) begin
            r_res_stole  <= 1'b1;
            r_res_stolen <= r_sel;
        end
    end

    assign o_voice         = 4'(r_res_voice);
    assign o_voice_valid   = r_res_valid;
    assign o_retriggered   = r_res_retrig;
    assign o_stole         = r_res_stole;
    assign o_stolen_voice  = 4'(r_res_stolen);
    assign o_played_note   = r_res_played;
    assign o_restart_phase = r_res_restart;
    assign o_active_voices = 5'(r_active);

    // checks
    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= VC_A)
        else $error("active voice count above voice count");

    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_free && !i_cmd.clear_all) |=> (r_active == $past(r_active) - ONE_AGE))
        else $error("freeing a voice did not drop the active count");

    a_alloc_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |=> r_map_vld[r_note])
        else $error("allocated note not mapped");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> (r_active == '0) && (r_map_vld == '0))
        else $error("reset all left voices active");

endmodule

[rtl/poly_voice_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_voice_allocator_unit
// polyphonic voice allocator with oldest-released voice stealing
// ----------------------------------------------------------------------------
// flow: reset_all, unmapped note_off and out-of-range voice_done end after
//   decode; a retrigger, mapped note_off and voice_done pass their own state;
//   a fresh note_on scans one voice per cycle for a free voice, or
//   if all are busy for one to steal, picks and frees it, then allocates
// throughput: one request at a time; start is taken again in the strobe cycle
// reset: synchronous; all voices free, note map invalid, configuration registers zero
module poly_voice_allocator_unit #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pva_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // request
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic [6:0]                  i_note,
    input  logic [6:0]                  i_velocity,
    input  logic [3:0]                  i_channel,
    input  logic [3:0]                  i_done_voice,
    // result
    output logic                        o_result_valid,
    output logic [3:0]                  o_voice,
    output logic                        o_voice_valid,
    output logic                        o_retriggered,
    output logic                        o_stole,
    output logic [3:0]                  o_stolen_voice,
    output logic [6:0]                  o_played_note,
    output logic                        o_restart_phase,
    output logic [4:0]                  o_active_voices
);
    import pva_pkg::*;

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // configuration registers
    pva_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer
    pva_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .i_status       (w_status),
        .o_cmd          (w_cmd)
    );

    // voice state and results
    pva_dp #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg           (w_cfg),
        .i_action        (i_action),
        .i_note          (i_note),
        .i_velocity      (i_velocity),
        .i_channel       (i_channel),
        .i_done_voice    (i_done_voice),
        .o_voice         (o_voice),
        .o_voice_valid   (o_voice_valid),
        .o_retriggered   (o_retriggered),
        .o_stole         (o_stole),
        .o_stolen_voice  (o_stolen_voice),
        .o_played_note   (o_played_note),
        .o_restart_phase (o_restart_phase),
        .o_active_voices (o_active_voices)
    );

endmodule

[verif/tb_poly_voice_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_poly_voice_allocator_unit
// self-checking bench for the polyphonic voice allocator: a behavioral copy
// of the voice table predicts every result, directed requests hit the steal,
// retrigger, release, clamp and ignore cases, then random request traffic
// runs under several register settings with random idle gaps
// ----------------------------------------------------------------------------
module tb_poly_voice_allocator_unit;
    import pva_pkg::*;

    localparam int VOICE_COUNT   = VOICE_COUNT_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = VOICE_COUNT + 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 300;
    localparam logic [CFG_AW-1:0] ADDR_TRANSPOSE  = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_PHASE_SYNC = 3'd4;

    // one allocator result as seen on the result ports
    typedef struct packed {
        logic [3:0] voice;
        logic       voice_valid;
        logic       retriggered;
        logic       stole;
        logic [3:0] stolen_voice;
        logic [6:0] played_note;
        logic       restart_phase;
        logic [4:0] active_voices;
    } t_allocation;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [6:0]  i_note;
    logic [6:0]  i_velocity;
    logic [3:0]  i_channel;
    logic [3:0]  i_done_voice;
    logic        o_result_valid;
    logic [3:0]  o_voice;
    logic        o_voice_valid;
    logic        o_retriggered;
    logic        o_stole;
    logic [3:0]  o_stolen_voice;
    logic [6:0]  o_played_note;
    logic        o_restart_phase;
    logic [4:0]  o_active_voices;

    // voice table copy
    logic [4:0]  slot_order    [VOICE_COUNT];
    logic [6:0]  slot_note     [VOICE_COUNT];
    logic [6:0]  slot_velocity [VOICE_COUNT];
    logic [3:0]  slot_channel  [VOICE_COUNT];
    logic        slot_released [VOICE_COUNT];
    logic        note_held     [128];
    int          note_slot     [128];
    logic [4:0]  voices_in_use;
    int          transpose_semis;
    logic        phase_sync_on;

    t_allocation allocations_due[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          no_idle_left = 0;

    poly_voice_allocator_unit #(
        .VOICE_COUNT(VOICE_COUNT)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_note          (i_note),
        .i_velocity      (i_velocity),
        .i_channel       (i_channel),
        .i_done_voice    (i_done_voice),
        .o_result_valid  (o_result_valid),
        .o_voice         (o_voice),
        .o_voice_valid   (o_voice_valid),
        .o_retriggered   (o_retriggered),
        .o_stole         (o_stole),
        .o_stolen_voice  (o_stolen_voice),
        .o_played_note   (o_played_note),
        .o_restart_phase (o_restart_phase),
        .o_active_voices (o_active_voices)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // voice table model
    // ------------------------------------------------------------------
    function automatic void clear_voice_table();
        int k;
        for (k = 0; k < VOICE_COUNT; k++) begin
            slot_order[k]    = '0;
            slot_note[k]     = '0;
            slot_velocity[k] = '0;
            slot_channel[k]  = '0;
            slot_released[k] = 1'b0;
        end
        for (k = 0; k < 128; k++) begin
            note_held[k] = 1'b0;
            note_slot[k] = 0;
        end
        voices_in_use   = '0;
        transpose_semis = 0;
        phase_sync_on   = 1'b0;
    endfunction

    // free one voice and close the gap in the age orders
    function automatic void release_slot(input int v);
        logic [4:0] removed;
        int k;
        int cnt;
        if (slot_order[v] == 0) return;
        removed = slot_order[v];
        note_held[slot_note[v]] = 1'b0;
        slot_order[v]    = '0;
        slot_note[v]     = '0;
        slot_velocity[v] = '0;
        slot_channel[v]  = '0;
        slot_released[v] = 1'b0;
        cnt = 0;
        for (k = 0; k < VOICE_COUNT; k++) begin
            if (slot_order[k] > removed) slot_order[k] = slot_order[k] - 5'd1;
            if (slot_order[k] != 0) cnt++;
        end
        voices_in_use = cnt[4:0];
    endfunction

    function automatic t_allocation compute_allocation(input t_action act,
                                                       input logic [6:0] note,
                                                       input logic [6:0] vel,
                                                       input logic [3:0] ch,
                                                       input logic [3:0] done);
        t_allocation r;
        int sum;
        int k;
        int idx;
        int pick;
        int best;
        logic [4:0] old;
        r = '0;
        case (act)
            ACT_NOTE_ON: begin
                sum = int'(note) + transpose_semis;
                if (sum < 0) sum = 0;
                if (sum > int'(NOTE_MAX)) sum = int'(NOTE_MAX);
                r.played_note = sum[6:0];
                if (note_held[note]) begin
                    // retrigger: move to newest, others close up
                    idx = note_slot[note];
                    old = slot_order[idx];
                    for (k = 0; k < VOICE_COUNT; k++)
                        if (slot_order[k] > old) slot_order[k] = slot_order[k] - 5'd1;
                    slot_order[idx]    = voices_in_use;
                    slot_velocity[idx] = vel;
                    slot_released[idx] = 1'b0;
                    r.voice       = idx[3:0];
                    r.voice_valid = 1'b1;
                    r.retriggered = 1'b1;
                end else begin
                    // all busy: oldest released voice, else order 1
                    if (voices_in_use >= VOICE_COUNT) begin
                        pick = -1;
                        best = 255;
                        for (k = 0; k < VOICE_COUNT; k++) begin
                            if (slot_order[k] != 0 && slot_released[k] &&
                                int'(slot_order[k]) < best) begin
                                best = int'(slot_order[k]);
                                pick = k;
                            end
                        end
                        for (k = 0; k < VOICE_COUNT; k++)
                            if (pick < 0 && slot_order[k] == 1) pick = k;
                        if (pick >= 0) begin
                            release_slot(pick);
                            r.stole        = 1'b1;
                            r.stolen_voice = pick[3:0];
                        end
                    end
                    // lowest free index
                    idx = -1;
                    for (k = 0; k < VOICE_COUNT; k++)
                        if (idx < 0 && slot_order[k] == 0) idx = k;
                    if (idx >= 0) begin
                        note_held[note]    = 1'b1;
                        note_slot[note]    = idx;
                        voices_in_use      = voices_in_use + 5'd1;
                        slot_order[idx]    = voices_in_use;
                        slot_note[idx]     = note;
                        slot_velocity[idx] = vel;
                        slot_channel[idx]  = ch;
                        slot_released[idx] = 1'b0;
                        r.voice         = idx[3:0];
                        r.voice_valid   = 1'b1;
                        r.restart_phase = phase_sync_on;
                    end
                end
            end
            ACT_NOTE_OFF: begin
                if (note_held[note]) begin
                    idx = note_slot[note];
                    slot_released[idx] = 1'b1;
                    r.voice       = idx[3:0];
                    r.voice_valid = 1'b1;
                end
            end
            ACT_VOICE_DONE: begin
                if (int'(done) < VOICE_COUNT && slot_order[done] != 0) begin
                    release_slot(int'(done));
                    r.voice       = done;
                    r.voice_valid = 1'b1;
                end
            end
            default: begin
                for (k = 0; k < VOICE_COUNT; k++) release_slot(k);
            end
        endcase
        r.active_voices = voices_in_use;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic string show_allocation(input t_allocation a);
        return $sformatf({"voice=%0d valid=%0b retrig=%0b stole=%0b stolen=%0d ",
                          "note=%0d restart=%0b active=%0d"},
                         a.voice, a.voice_valid, a.retriggered, a.stole,
                         a.stolen_voice, a.played_note, a.restart_phase,
                         a.active_voices);
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_allocation got;
        t_allocation want;
        if (i_rst_n && o_result_valid) begin
            got.voice         = o_voice;
            got.voice_valid   = o_voice_valid;
            got.retriggered   = o_retriggered;
            got.stole         = o_stole;
            got.stolen_voice  = o_stolen_voice;
            got.played_note   = o_played_note;
            got.restart_phase = o_restart_phase;
            got.active_voices = o_active_voices;
            if (allocations_due.size() == 0) begin
                note_mismatch({"result with no request pending: ", show_allocation(got)});
            end else begin
                want = allocations_due.pop_front();
                if (got !== want)
                    note_mismatch({"expected ", show_allocation(want),
                                   " got ", show_allocation(got)});
            end
        end
    end

    // ------------------------------------------------------------------
    // request and register access
    // ------------------------------------------------------------------
    // mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap();
        int r;
        if (no_idle_left > 0) begin
            no_idle_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            no_idle_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    task automatic issue_request(input t_action act, input logic [6:0] note,
                                 input logic [6:0] vel, input logic [3:0] ch,
                                 input logic [3:0] done);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_note       <= note;
        i_velocity   <= vel;
        i_channel    <= ch;
        i_done_voice <= done;
        do @(posedge i_clk); while (busy);
        allocations_due.push_back(compute_allocation(act, note, vel, ch, done));
    endtask

    task automatic wait_for_idle();
        start <= 1'b0;
        while (allocations_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // write both registers while idle and read them back
    task automatic set_config(input int semis, input logic sync);
        logic [31:0] tbits;
        logic [31:0] rd;
        tbits = semis;
        wait_for_idle();
        cfg_access(1'b1, ADDR_TRANSPOSE, {25'b0, tbits[6:0]}, rd);
        cfg_access(1'b1, ADDR_PHASE_SYNC, {31'b0, sync}, rd);
        cfg_access(1'b0, ADDR_TRANSPOSE, 32'b0, rd);
        if (rd[6:0] !== tbits[6:0])
            note_mismatch($sformatf("transpose readback %0h, wrote %0h", rd[6:0], tbits[6:0]));
        cfg_access(1'b0, ADDR_PHASE_SYNC, 32'b0, rd);
        if (rd[0] !== sync)
            note_mismatch($sformatf("phase sync readback %0b, wrote %0b", rd[0], sync));
        transpose_semis = semis;
        phase_sync_on   = sync;
    endtask

    function automatic int random_active_slot();
        int base;
        int k;
        int v;
        base = $urandom_range(0, VOICE_COUNT - 1);
        for (k = 0; k < VOICE_COUNT; k++) begin
            v = (base + k) % VOICE_COUNT;
            if (slot_order[v] != 0) return v;
        end
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // fill every voice, then steal with and without released voices
    task automatic test_fill_and_steal();
        int k;
        logic [6:0] note;
        for (k = 0; k < VOICE_COUNT; k++) begin
            note = (k == VOICE_COUNT - 1) ? NOTE_MAX : 7'(k * 8);
            issue_request(ACT_NOTE_ON, note, k[0] ? 7'd127 : 7'd0, k[3:0], ~k[3:0]);
        end
        // nothing released: order 1 is taken
        issue_request(ACT_NOTE_ON, 7'd1, 7'd64, 4'd5, 4'd0);
        // two released: the older one is taken
        issue_request(ACT_NOTE_OFF, 7'd40, 7'd10, 4'd0, 4'd15);
        issue_request(ACT_NOTE_OFF, 7'd24, 7'd20, 4'd1, 4'd3);
        issue_request(ACT_NOTE_ON, 7'd2, 7'd90, 4'd9, 4'd0);
    endtask

    // retrigger of released and held notes, note off for an unmapped note
    task automatic test_retrigger_release();
        issue_request(ACT_NOTE_ON, 7'd40, 7'd33, 4'd2, 4'd0);
        issue_request(ACT_NOTE_ON, 7'd64, 7'd77, 4'd12, 4'd0);
        issue_request(ACT_NOTE_OFF, 7'd100, 7'd0, 4'd0, 4'd0);
    endtask

    // voice done on an active voice, then on the same now free voice
    task automatic test_voice_done();
        issue_request(ACT_VOICE_DONE, 7'd0, 7'd0, 4'd0, 4'd7);
        issue_request(ACT_VOICE_DONE, 7'd127, 7'd127, 4'd15, 4'd7);
    endtask

    task automatic test_reset_all();
        issue_request(ACT_RESET_ALL, 7'd55, 7'd55, 4'd5, 4'd5);
    endtask

    // transposed note clamped at the low end, and passed through unclamped
    task automatic test_transpose_clamp();
        set_config(-64, 1'b0);
        issue_request(ACT_NOTE_ON, 7'd0, 7'd1, 4'd0, 4'd0);
        issue_request(ACT_NOTE_ON, 7'd127, 7'd2, 4'd1, 4'd0);
        issue_request(ACT_NOTE_ON, 7'd70, 7'd3, 4'd2, 4'd0);
        issue_request(ACT_VOICE_DONE, 7'd0, 7'd0, 4'd0, 4'd15);
        issue_request(ACT_RESET_ALL, 7'd0, 7'd0, 4'd0, 4'd0);
    endtask

    // mostly playable traffic on a small note range, some noise
    task automatic test_random_traffic(input int count);
        int k;
        int r;
        int v;
        t_action act;
        logic [6:0] note;
        logic [6:0] vel;
        logic [3:0] ch;
        logic [3:0] done;
        for (k = 0; k < count; k++) begin
            r    = $urandom_range(0, 99);
            note = 7'($urandom_range(0, 127));
            vel  = 7'($urandom_range(0, 127));
            ch   = 4'($urandom_range(0, 15));
            done = 4'($urandom_range(0, 15));
            if (r < 52) begin
                act = ACT_NOTE_ON;
                if ($urandom_range(0, 3) != 0) note = 7'($urandom_range(40, 75));
            end else if (r < 80) begin
                act = ACT_NOTE_OFF;
                v = random_active_slot();
                if (v >= 0 && $urandom_range(0, 5) != 0) note = slot_note[v];
            end else if (r < 99) begin
                act = ACT_VOICE_DONE;
                v = random_active_slot();
                if (v >= 0 && $urandom_range(0, 4) != 0) done = v[3:0];
            end else begin
                act = ACT_RESET_ALL;
            end
            issue_request(act, note, vel, ch, done);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        clear_voice_table();
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        start        <= 1'b0;
        i_action     <= ACT_NOTE_ON;
        i_note       <= '0;
        i_velocity   <= '0;
        i_channel    <= '0;
        i_done_voice <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(63, 1'b1);
        test_fill_and_steal();
        test_retrigger_release();
        test_voice_done();
        test_reset_all();
        test_transpose_clamp();

        set_config(0, 1'b0);
        test_random_traffic(PHASE_ITEMS);
        set_config(-64, 1'b1);
        test_random_traffic(PHASE_ITEMS);
        set_config(63, 1'b0);
        test_random_traffic(PHASE_ITEMS);
        set_config($urandom_range(0, 127) - 64, 1'($urandom_range(0, 1)));
        test_random_traffic(PHASE_ITEMS);

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && allocations_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
